// ===== rtl/ut_pkg.sv =====
// Shared constants and helpers for the Unicode transcoder.
// Used by unicode_transcoder and ut_checker; no dependencies.
package ut_pkg;

    // direction register codes
    localparam logic [2:0] DIR_U16_U8  = 3'd0;
    localparam logic [2:0] DIR_U32_U8  = 3'd1;
    localparam logic [2:0] DIR_U8_U16  = 3'd2;
    localparam logic [2:0] DIR_U32_U16 = 3'd3;
    localparam logic [2:0] DIR_U8_U32  = 3'd4;
    localparam logic [2:0] DIR_U16_U32 = 3'd5;

    // encoding kinds
    localparam logic [1:0] ENC_U8   = 2'd0;
    localparam logic [1:0] ENC_U16  = 2'd1;
    localparam logic [1:0] ENC_U32  = 2'd2;
    localparam logic [1:0] ENC_NONE = 2'd3;

    // error codes
    localparam logic [1:0] ERR_NONE        = 2'd0;
    localparam logic [1:0] ERR_BAD_LEAD    = 2'd1;
    localparam logic [1:0] ERR_UNSUPPORTED = 2'd2;
    localparam logic [1:0] ERR_TRUNCATED   = 2'd3;

    // register map
    localparam int          PADDR_W      = 3;
    localparam logic [2:0]  ADDR_DIRECTION = 3'd0;

    localparam int MAX_RESULTS = 4;

    typedef logic [31:0] unit_t;

    function automatic logic [1:0] src_of_dir(input logic [2:0] dir);
        logic [1:0] s;
        case (dir)
            DIR_U16_U8, DIR_U16_U32: s = ENC_U16;
            DIR_U32_U8, DIR_U32_U16: s = ENC_U32;
            DIR_U8_U16, DIR_U8_U32:  s = ENC_U8;
            default:                 s = ENC_NONE;
        endcase
        return s;
    endfunction

    function automatic logic [1:0] dst_of_dir(input logic [2:0] dir);
        logic [1:0] d;
        case (dir)
            DIR_U16_U8, DIR_U32_U8:   d = ENC_U8;
            DIR_U8_U16, DIR_U32_U16:  d = ENC_U16;
            DIR_U8_U32, DIR_U16_U32:  d = ENC_U32;
            default:                  d = ENC_NONE;
        endcase
        return d;
    endfunction

endpackage

// ===== rtl/unicode_transcoder.sv =====
// Unicode transcoder top level: decoder, encoder, four-word result buffer, APB register.
// Depends on ut_pkg.
// The first result word of an accepted input word is offered in the next cycle.
// Throughput: one input word per cycle while each yields at most one result word and results
// are taken; a word that expands to k result words holds s_ready low till the last one leaves.
// Reset (aresetn, synchronous, active low): direction returns to UTF-16 to UTF-8, decoder
// state clears and the result buffer empties.
module unicode_transcoder
    import ut_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    // source words
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [31:0]        s_code_unit,
    input  logic               s_end_of_string,
    // result words
    output logic               m_valid,
    input  logic               m_ready,
    output logic [31:0]        m_out_unit,
    output logic               m_unit_valid,
    output logic               m_last_of_run,
    output logic               m_string_done,
    output logic [1:0]         m_error_code,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [2:0]  direction_reg;
    logic [20:0] acc_reg, acc_next;
    logic [1:0]  bytes_left_reg, bytes_left_next;
    logic [9:0]  hsb_reg, hsb_next;
    logic        hp_reg, hp_next;

    unit_t       buf_reg [MAX_RESULTS];
    unit_t       units   [MAX_RESULTS];
    logic [2:0]  n_reg, n;
    logic [1:0]  idx_reg;
    logic        eos_reg;
    logic        uv_reg, uv;
    logic [1:0]  err_reg, err;

    logic [1:0]  src, dst;
    logic [7:0]  b;
    logic [15:0] u;
    logic [31:0] cp;
    logic [20:0] c;
    logic        have, trunc;
    logic        s_acc, m_acc, at_last, cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_DIRECTION);
    assign prdata = (paddr == ADDR_DIRECTION) ? {29'd0, direction_reg} : 32'd0;

    assign src = src_of_dir(direction_reg);
    assign dst = dst_of_dir(direction_reg);
    assign b   = s_code_unit[7:0];
    assign u   = s_code_unit[15:0];
    assign c   = cp[20:0] - 21'h10000;

    assign at_last = ({1'b0, idx_reg} == (n_reg - 3'd1));
    assign m_valid = (n_reg != 3'd0);
    assign m_acc   = m_valid && m_ready;
    // take the next word while the buffer is empty or while the last buffered result leaves
    assign s_ready = !m_valid || (m_ready && at_last);
    assign s_acc   = s_valid && s_ready;

    always_comb begin
        acc_next        = acc_reg;
        bytes_left_next = bytes_left_reg;
        hsb_next        = hsb_reg;
        hp_next         = hp_reg;
        have            = 1'b0;
        cp              = 32'd0;
        err             = ERR_NONE;
        n               = 3'd0;
        uv              = 1'b1;
        trunc           = 1'b0;
        for (int i = 0; i < MAX_RESULTS; i++) begin
            units[i] = 32'd0;
        end

        // decode
        case (src)
            ENC_U8: begin
                if (bytes_left_reg != 2'd0) begin
                    acc_next        = {acc_reg[14:0], b[5:0]};
                    bytes_left_next = bytes_left_reg - 2'd1;
                    if (bytes_left_next == 2'd0) begin
                        cp   = {11'd0, acc_next};
                        have = 1'b1;
                    end
                end else if (!b[7]) begin
                    cp   = {24'd0, b};
                    have = 1'b1;
                end else if (b[7:5] == 3'b110) begin
                    acc_next        = {16'd0, b[4:0]};
                    bytes_left_next = 2'd1;
                end else if (b[7:4] == 4'b1110) begin
                    acc_next        = {17'd0, b[3:0]};
                    bytes_left_next = 2'd2;
                end else if (b[7:3] == 5'b11110) begin
                    acc_next        = {18'd0, b[2:0]};
                    bytes_left_next = 2'd3;
                end else begin
                    cp   = {24'd0, b};
                    err  = ERR_BAD_LEAD;
                    have = 1'b1;
                end
            end
            ENC_U16: begin
                if (hp_reg) begin
                    cp      = {11'd0, {1'b0, hsb_reg, u[9:0]} + 21'h10000};
                    hp_next = 1'b0;
                    have    = 1'b1;
                end else if (u[15:10] == 6'b110110) begin
                    hsb_next = u[9:0];
                    hp_next  = 1'b1;
                end else begin
                    cp   = {16'd0, u};
                    have = 1'b1;
                end
            end
            ENC_U32: begin
                cp   = s_code_unit;
                have = 1'b1;
            end
            default: ;
        endcase

        // encode
        if (have) begin
            if (dst == ENC_U32) begin
                units[0] = cp;
                n        = 3'd1;
            end else if (cp[31:21] != 11'd0) begin
                units[0] = {24'd0, cp[7:0]};
                err      = ERR_UNSUPPORTED;
                n        = 3'd1;
            end else if (dst == ENC_U16) begin
                if (cp[20:16] == 5'd0) begin
                    units[0] = cp;
                    n        = 3'd1;
                end else begin
                    units[0] = {16'd0, 16'hD800 | {5'd0, c[20:10]}};
                    units[1] = {16'd0, 6'b110111, c[9:0]};
                    n        = 3'd2;
                end
            end else begin
                if (cp[20:7] == 14'd0) begin
                    units[0] = cp;
                    n        = 3'd1;
                end else if (cp[20:11] == 10'd0) begin
                    units[0] = {24'd0, 3'b110, cp[10:6]};
                    units[1] = {24'd0, 2'b10, cp[5:0]};
                    n        = 3'd2;
                end else if (cp[20:16] == 5'd0) begin
                    units[0] = {24'd0, 4'b1110, cp[15:12]};
                    units[1] = {24'd0, 2'b10, cp[11:6]};
                    units[2] = {24'd0, 2'b10, cp[5:0]};
                    n        = 3'd3;
                end else begin
                    units[0] = {24'd0, 5'b11110, cp[20:18]};
                    units[1] = {24'd0, 2'b10, cp[17:12]};
                    units[2] = {24'd0, 2'b10, cp[11:6]};
                    units[3] = {24'd0, 2'b10, cp[5:0]};
                    n        = 3'd4;
                end
            end
        end

        // end of string: drop any partial sequence; if no result word is due, emit an empty one
        if (s_end_of_string) begin
            trunc           = (bytes_left_next != 2'd0) || hp_next;
            bytes_left_next = 2'd0;
            hp_next         = 1'b0;
            if (n == 3'd0) begin
                n   = 3'd1;
                uv  = 1'b0;
                err = trunc ? ERR_TRUNCATED : ERR_NONE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            direction_reg  <= DIR_U16_U8;
            acc_reg        <= '0;
            bytes_left_reg <= '0;
            hsb_reg        <= '0;
            hp_reg         <= 1'b0;
            n_reg          <= '0;
            idx_reg        <= '0;
        end else begin
            if (cfg_wr) begin
                direction_reg  <= pwdata[2:0];
                bytes_left_reg <= '0;
                hp_reg         <= 1'b0;
            end else if (s_acc) begin
                acc_reg        <= acc_next;
                bytes_left_reg <= bytes_left_next;
                hsb_reg        <= hsb_next;
                hp_reg         <= hp_next;
            end
            if (s_acc) begin
                n_reg   <= n;
                idx_reg <= '0;
            end else if (m_acc) begin
                if (at_last) begin
                    n_reg <= '0;
                end else begin
                    idx_reg <= idx_reg + 2'd1;
                end
            end
        end
    end

    // result payload, loaded with each accepted word
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            for (int i = 0; i < MAX_RESULTS; i++) begin
                buf_reg[i] <= units[i];
            end
            eos_reg <= s_end_of_string;
            uv_reg  <= uv;
            err_reg <= err;
        end
    end

    assign m_out_unit    = buf_reg[idx_reg];
    assign m_unit_valid  = uv_reg;
    assign m_last_of_run = at_last;
    assign m_string_done = eos_reg;
    assign m_error_code  = err_reg;

endmodule

// ===== rtl/ut_checker.sv =====
// Port-level assertions for the Unicode transcoder, bound to the top level.
// Depends on ut_pkg and unicode_transcoder.
module ut_checker
    import ut_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_out_unit,
    input logic        m_unit_valid,
    input logic        m_last_of_run,
    input logic        m_string_done,
    input logic [1:0]  m_error_code
);

    // stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_unit) && $stable(m_last_of_run))
        else $error("stalled result word changed");

    // an empty result closes both run and string
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_unit_valid |-> m_last_of_run && m_string_done)
        else $error("empty result without end of run and string");

    // truncation is only reported on an empty result
    a_trunc: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_error_code == ERR_TRUNCATED) |-> !m_unit_valid)
        else $error("truncation flagged on a carried unit");

    // remaining words of a run follow without a gap
    a_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_of_run |=> m_valid && $stable(m_string_done)
            && $stable(m_error_code))
        else $error("gap or field change inside a run");

endmodule

bind unicode_transcoder ut_checker u_ut_checker (.*);

// ===== verif/unicode_transcoder_tb.sv =====
// Self-checking testbench for unicode_transcoder: directed and random strings in all
// directions, with random idling on both word channels. Depends on ut_pkg and the RTL.
module unicode_transcoder_tb
    import ut_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] DIR_SPARE_LO = 3'd6;
    localparam logic [2:0] DIR_SPARE_HI = 3'd7;
    localparam int         MAX_REPORTS  = 40;

    typedef struct packed {
        logic [31:0] unit;
        logic        eos;
    } src_word_t;

    typedef struct packed {
        logic [31:0] out_unit;
        logic        unit_valid;
        logic        last_of_run;
        logic        string_done;
        logic [1:0]  error_code;
    } result_t;

    logic               aclk            = 1'b0;
    logic               aresetn         = 1'b0;
    logic               s_valid         = 1'b0;
    logic               s_ready;
    logic [31:0]        s_code_unit     = '0;
    logic               s_end_of_string = 1'b0;
    logic               m_valid;
    logic               m_ready         = 1'b0;
    logic [31:0]        m_out_unit;
    logic               m_unit_valid;
    logic               m_last_of_run;
    logic               m_string_done;
    logic [1:0]         m_error_code;
    logic               psel            = 1'b0;
    logic               penable         = 1'b0;
    logic               pwrite          = 1'b0;
    logic [PADDR_W-1:0] paddr           = '0;
    logic [31:0]        pwdata          = '0;
    logic [31:0]        prdata;
    logic               pready;

    src_word_t pending_words[$];
    result_t   expected_units[$];
    int        src_idle_pct   = 0;
    int        dst_idle_pct   = 0;
    int        fail_count     = 0;
    int        words_accepted = 0;
    int        words_queued   = 0;
    int        results_seen   = 0;

    // predicted decoder state and direction register
    logic [2:0]  dir_q     = DIR_U16_U8;
    logic [20:0] acc_q     = '0;
    logic [1:0]  left_q    = '0;
    logic [9:0]  hi_bits_q = '0;
    logic        hi_pend_q = 1'b0;

    unicode_transcoder dut (.*);

    always #4 aclk = ~aclk;

    function automatic void report(input string what, input logic [31:0] exp,
                                   input logic [31:0] act);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%0t: %s expected %h got %h", $time, what, exp, act);
    endfunction

    // {source encoding, destination encoding}
    function automatic logic [3:0] kinds_of(input logic [2:0] d);
        case (d)
            DIR_U16_U8:  return {ENC_U16, ENC_U8};
            DIR_U32_U8:  return {ENC_U32, ENC_U8};
            DIR_U8_U16:  return {ENC_U8, ENC_U16};
            DIR_U32_U16: return {ENC_U32, ENC_U16};
            DIR_U8_U32:  return {ENC_U8, ENC_U32};
            DIR_U16_U32: return {ENC_U16, ENC_U32};
            default:     return {ENC_NONE, ENC_NONE};
        endcase
    endfunction

    function automatic int encode_point(input logic [31:0] cp, input logic [1:0] err,
                                        input logic [1:0] dst, output logic [3:0][31:0] w,
                                        output logic [1:0] e);
        logic [31:0] c;
        w = '0;
        e = err;
        c = cp - 32'h10000;
        if (dst == ENC_U32) begin
            w[0] = cp;
            return 1;
        end
        if (cp[31:21] != '0) begin
            w[0] = {24'd0, cp[7:0]};
            e = ERR_UNSUPPORTED;
            return 1;
        end
        if (dst == ENC_U16) begin
            if (cp[31:16] == '0) begin
                w[0] = cp;
                return 1;
            end
            w[0] = (32'hD800 | (c >> 10)) & 32'hFFFF;
            w[1] = 32'hDC00 | (c & 32'h3FF);
            return 2;
        end
        if (cp < 32'h80) begin
            w[0] = cp;
            return 1;
        end
        if (cp < 32'h800) begin
            w[0] = 32'hC0 | (cp >> 6);
            w[1] = 32'h80 | (cp & 32'h3F);
            return 2;
        end
        if (cp < 32'h10000) begin
            w[0] = 32'hE0 | (cp >> 12);
            w[1] = 32'h80 | ((cp >> 6) & 32'h3F);
            w[2] = 32'h80 | (cp & 32'h3F);
            return 3;
        end
        w[0] = 32'hF0 | (cp >> 18);
        w[1] = 32'h80 | ((cp >> 12) & 32'h3F);
        w[2] = 32'h80 | ((cp >> 6) & 32'h3F);
        w[3] = 32'h80 | (cp & 32'h3F);
        return 4;
    endfunction

    // advance the decoder by one source word and queue the result words it yields
    function automatic void predict_units(input logic [31:0] cu, input logic eos);
        logic [3:0]       kinds;
        logic [1:0]       err;
        logic [1:0]       out_err;
        logic [31:0]      cp;
        logic [3:0][31:0] words;
        logic [7:0]       b;
        logic [15:0]      u;
        logic             have;
        logic             trunc;
        logic             empty;
        int               n;
        result_t          r;
        kinds   = kinds_of(dir_q);
        err     = ERR_NONE;
        out_err = ERR_NONE;
        cp      = '0;
        words   = '0;
        have    = 1'b0;
        trunc   = 1'b0;
        empty   = 1'b0;
        n       = 0;
        b       = cu[7:0];
        u       = cu[15:0];
        if (kinds[3:2] == ENC_U8) begin
            if (left_q != '0) begin
                acc_q  = {acc_q[14:0], b[5:0]};
                left_q = left_q - 2'd1;
                if (left_q == '0) begin
                    cp   = {11'd0, acc_q};
                    have = 1'b1;
                end
            end else if (!b[7]) begin
                cp   = {24'd0, b};
                have = 1'b1;
            end else if (b[7:5] == 3'b110) begin
                acc_q  = {16'd0, b[4:0]};
                left_q = 2'd1;
            end else if (b[7:4] == 4'b1110) begin
                acc_q  = {17'd0, b[3:0]};
                left_q = 2'd2;
            end else if (b[7:3] == 5'b11110) begin
                acc_q  = {18'd0, b[2:0]};
                left_q = 2'd3;
            end else begin
                cp   = {24'd0, b};
                err  = ERR_BAD_LEAD;
                have = 1'b1;
            end
        end else if (kinds[3:2] == ENC_U16) begin
            if (hi_pend_q) begin
                cp        = {12'd0, hi_bits_q, u[9:0]} + 32'h10000;
                hi_pend_q = 1'b0;
                have      = 1'b1;
            end else if (u[15:10] == 6'b110110) begin
                hi_bits_q = u[9:0];
                hi_pend_q = 1'b1;
            end else begin
                cp   = {16'd0, u};
                have = 1'b1;
            end
        end else if (kinds[3:2] == ENC_U32) begin
            cp   = cu;
            have = 1'b1;
        end
        if (have)
            n = encode_point(cp, err, kinds[1:0], words, out_err);
        if (eos) begin
            trunc     = (left_q != '0) || hi_pend_q;
            left_q    = '0;
            hi_pend_q = 1'b0;
            if (n == 0) begin
                out_err = trunc ? ERR_TRUNCATED : ERR_NONE;
                empty   = 1'b1;
                n       = 1;
            end
        end
        for (int k = 0; k < n; k++) begin
            r.out_unit    = words[k];
            r.unit_valid  = !empty;
            r.last_of_run = (k == n - 1);
            r.string_done = eos;
            r.error_code  = out_err;
            expected_units.insert(expected_units.size(), r);
        end
    endfunction

    function automatic logic [31:0] rand_point(input bit for_u16);
        logic [31:0] cp;
        case ($urandom_range(3))
            0: cp = $urandom_range(32'h7F);
            1: cp = $urandom_range(32'h7FF, 32'h80);
            2: begin
                cp = $urandom_range(32'hFFFF, 32'h800);
                // keep UTF-16 text clear of the surrogate block
                if (for_u16 && cp[15:11] == 5'b11011) cp[15:11] = 5'b11100;
            end
            default: cp = $urandom_range(for_u16 ? 32'h10FFFF : 32'h1FFFFF, 32'h10000);
        endcase
        return cp;
    endfunction

    task automatic put(input logic [31:0] u, input logic eos);
        pending_words.insert(pending_words.size(), {u, eos});
        words_queued++;
    endtask

    // one well-formed string with random content, now and then broken or run on
    task automatic queue_string(input logic [2:0] d);
        logic [1:0]       src;
        logic [1:0]       e;
        logic [3:0][31:0] w;
        logic [31:0]      cp;
        logic [31:0]      u;
        logic [31:0]      units[$];
        int               n;
        int               len;
        logic [3:0]       kinds;
        kinds = kinds_of(d);
        src   = kinds[3:2];
        len   = $urandom_range(6, 1);
        repeat (len) begin
            if (src == ENC_NONE) begin
                cp = $urandom;
            end else if (src == ENC_U32) begin
                case ($urandom_range(7))
                    0:       cp = $urandom;
                    1:       cp = $urandom_range(32'h1FFFFF, 32'h110000);
                    default: cp = rand_point(1'b0);
                endcase
            end else begin
                cp = rand_point(src == ENC_U16);
            end
            n = encode_point(cp, ERR_NONE, (src == ENC_NONE) ? ENC_U32 : src, w, e);
            for (int k = 0; k < n; k++) units.insert(units.size(), w[k]);
        end
        case ($urandom_range(9))
            0: units.push_front($urandom);
            1: units.insert(units.size(), $urandom);
            2: if (units.size() > 1) void'(units.pop_back());
            default: ;
        endcase
        foreach (units[i]) begin
            u = units[i];
            if (src == ENC_U8 && $urandom_range(3) == 0) u[31:8] = 24'($urandom);
            if (src == ENC_U16 && $urandom_range(3) == 0) u[31:16] = 16'($urandom);
            put(u, (i == units.size() - 1) && ($urandom_range(9) != 0));
        end
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_words.size() != 0 || s_valid || expected_units.size() != 0);
        // words that yield nothing may still be in flight
        repeat (4) @(negedge aclk);
    endtask

    task automatic set_direction(input logic [2:0] d);
        wait_drained();
        @(posedge aclk);
        psel   <= 1'b1;
        pwrite <= 1'b1;
        paddr  <= ADDR_DIRECTION;
        pwdata <= {29'd0, d};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        // register and decoder clear take effect at this edge
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
    endtask

    always @(posedge aclk) begin : source_driver
        src_word_t w;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            // track the direction register; a write also clears the decoder
            if (psel && penable && pready && paddr == ADDR_DIRECTION) begin
                if (pwrite) begin
                    dir_q     = pwdata[2:0];
                    left_q    = '0;
                    hi_pend_q = 1'b0;
                end else if (prdata[2:0] !== dir_q) begin
                    report("direction readback", {29'd0, dir_q}, prdata);
                end
            end
            if (s_valid && s_ready) begin
                predict_units(s_code_unit, s_end_of_string);
                words_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (pending_words.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    w = pending_words.pop_front();
                    s_valid         <= 1'b1;
                    s_code_unit     <= w.unit;
                    s_end_of_string <= w.eos;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : result_monitor
        result_t exp_r;
        m_ready <= ($urandom_range(99) >= dst_idle_pct);
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_units.size() == 0) begin
                report("unexpected result word", '0, m_out_unit);
            end else begin
                exp_r = expected_units.pop_front();
                if (m_out_unit !== exp_r.out_unit)
                    report("out_unit", exp_r.out_unit, m_out_unit);
                if (m_unit_valid !== exp_r.unit_valid)
                    report("unit_valid", 32'(exp_r.unit_valid), 32'(m_unit_valid));
                if (m_last_of_run !== exp_r.last_of_run)
                    report("last_of_run", 32'(exp_r.last_of_run), 32'(m_last_of_run));
                if (m_string_done !== exp_r.string_done)
                    report("string_done", 32'(exp_r.string_done), 32'(m_string_done));
                if (m_error_code !== exp_r.error_code)
                    report("error_code", 32'(exp_r.error_code), 32'(m_error_code));
            end
        end
    end

    initial begin
        logic [2:0] phase_dirs [0:11];
        int         target;
        phase_dirs = '{DIR_U16_U8, DIR_U32_U16, DIR_U8_U32, DIR_SPARE_HI,
                       DIR_U8_U16, DIR_U16_U32, DIR_U32_U8, DIR_U8_U16,
                       DIR_SPARE_LO, DIR_U16_U8, DIR_U8_U32, DIR_U32_U16};
        src_idle_pct = 6;
        dst_idle_pct = 73;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // UTF-8 decoding: shortest and longest forms, a bad lead, cut-off sequence
        set_direction(DIR_U8_U16);
        put(32'h00, 1'b0);
        put(32'hC3, 1'b0); put(32'hA9, 1'b0);
        put(32'hE2, 1'b0); put(32'h82, 1'b0); put(32'hAC, 1'b0);
        put(32'hF4, 1'b0); put(32'h8F, 1'b0); put(32'hBF, 1'b0); put(32'hBF, 1'b0);
        put(32'hFF, 1'b0);
        put(32'hF0, 1'b0); put(32'h9F, 1'b1);
        // surrogate pair, lone low surrogate, top of the BMP, dangling high surrogate
        set_direction(DIR_U16_U8);
        put(32'hD83D, 1'b0); put(32'hDE00, 1'b0);
        put(32'hDC00, 1'b0);
        put(32'hFFFF, 1'b0);
        put(32'hD800, 1'b1);
        // code points beyond 21 bits and beyond the Unicode range
        set_direction(DIR_U32_U8);
        put(32'hFFFF_FFFF, 1'b0); put(32'h001F_FFFF, 1'b0); put(32'h0000_007F, 1'b1);
        set_direction(DIR_U32_U16);
        put(32'h0020_0000, 1'b0); put(32'h001F_FFFF, 1'b1);
        set_direction(DIR_U8_U32);
        put(32'h41, 1'b1);
        set_direction(DIR_U16_U32);
        put(32'hDBFF, 1'b0); put(32'hDFFF, 1'b1);
        set_direction(DIR_SPARE_HI);
        put(32'h41, 1'b1);

        foreach (phase_dirs[p]) begin
            case (p / 4)
                0: begin src_idle_pct = 6;  dst_idle_pct = 73; end
                1: begin src_idle_pct = 73; dst_idle_pct = 6;  end
                default: begin src_idle_pct = 0; dst_idle_pct = 0; end
            endcase
            set_direction(phase_dirs[p]);
            target = words_queued + ((kinds_of(phase_dirs[p]) == {ENC_NONE, ENC_NONE}) ? 8 : 30);
            while (words_queued < target) queue_string(phase_dirs[p]);
        end

        wait_drained();
        repeat (10) @(negedge aclk);
        $display("Covered %0d source words and %0d result words across all six directions,",
                 words_accepted, results_seen);
        $display("the two unused direction codes, bad leads, truncation and oversized points.");
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/ut_pkg.sv
rtl/unicode_transcoder.sv
rtl/ut_checker.sv
verif/unicode_transcoder_tb.sv
